/* src/rpzab_pkg.sv */
package rpzab_pkg;

	localparam int MAX_BLOCKS_ACROSS = 256;
	localparam int MAX_BLOCKS_DOWN = 256;

	// Configuration register indexes.
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [8:0] RESET_WIDTH = 9'd80;
	localparam logic [8:0] RESET_HEIGHT = 9'd60;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OPCODE = 2'd1;
	localparam logic [1:0] ERR_OVERRUN = 2'd2;

	typedef enum logic [3:0] {
		PH_HDR = 4'd0,
		PH_OPC = 4'd1,
		PH_A_LO = 4'd2,
		PH_PEEK = 4'd3,
		PH_C16_HI = 4'd4,
		PH_C16_LO = 4'd5,
		PH_FILL_HI = 4'd6,
		PH_FILL_LO = 4'd7,
		PH_PA_HI = 4'd8,
		PH_PA_LO = 4'd9,
		PH_PB_HI = 4'd10,
		PH_PB_LO = 4'd11,
		PH_IDX = 4'd12,
		PH_SKIP_RUN = 4'd13,
		PH_FILL_RUN = 4'd14,
		PH_ERR_STOP = 4'd15
	} phase_t;

	typedef struct packed {
		logic [7:0] col;
		logic [7:0] line;
		logic [1:0] row;
		logic all;
		logic [3:0] mask;
		logic [23:0] px0;
		logic [23:0] px1;
		logic [23:0] px2;
		logic [23:0] px3;
		logic [1:0] err;
	} res_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic push_new;
		logic push_pend;
		logic stash;
		logic close;
	} cmd_t;

	typedef struct packed {
		logic gen;
		logic byte_done;
		logic out_busy;
		logic pend_valid;
		logic last;
	} stat_t;

	function automatic logic [23:0] expand(logic [14:0] c);
		return {c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
	endfunction

	function automatic logic [14:0] mix_color(logic [14:0] a, logic [14:0] b,
			logic [4:0] wa, logic [4:0] wb);
		logic [14:0] r;
		logic [9:0] s;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			s = 10'(wa * a[i*5 +: 5]) + 10'(wb * b[i*5 +: 5]);
			r[i*5 +: 5] = s[9:5];
		end
		return r;
	endfunction

	function automatic logic [8:0] clampdim(logic [8:0] v, logic [8:0] mx);
		logic [8:0] r;
		r = v;
		if (v == 9'd0) begin
			r = 9'd1;
		end else if (v > mx) begin
			r = mx;
		end
		return r;
	endfunction

endpackage

/* src/rpzab_ctrl.sv */
module rpzab_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rpzab_pkg::stat_t st,
	output rpzab_pkg::cmd_t cmd
);
	import rpzab_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_STEP = 3'b010,
		ST_FLUSH = 3'b100
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic can_step;

	// A step that makes a result needs room in the output register, unless
	// the result only goes into the hold slot of a final byte.
	assign can_step = !(st.gen && (st.last ? st.pend_valid : 1'b1) && st.out_busy);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (can_step) begin
					cmd.step = 1'b1;
					cmd.push_new = st.gen && !st.last;
					cmd.push_pend = st.gen && st.last && st.pend_valid;
					cmd.stash = st.gen && st.last;
					if (st.byte_done) begin
						state_d = st.last ? ST_FLUSH : ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (!st.out_busy) begin
					cmd.close = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/rpzab_datapath.sv */
module rpzab_datapath (
	input logic clk,
	input logic arst_n,
	input logic cfg_write_en,
	input logic cfg_index,
	input logic [8:0] cfg_data,
	input logic [7:0] data_byte,
	input logic chunk_last,
	input logic out_ready,
	input rpzab_pkg::cmd_t cmd,
	output rpzab_pkg::stat_t st,
	output logic out_valid,
	output rpzab_pkg::res_t out_res,
	output logic out_done
);
	import rpzab_pkg::*;

	logic [8:0] width_cfg_q, height_cfg_q;
	logic [7:0] byte_q;
	logic last_q;

	phase_t phase_q, n_phase;
	logic [1:0] hc_q, n_hc;
	logic [5:0] run_q, n_run;
	logic [14:0] first_q, n_first, second_q, n_second, p1_q, n_p1, p2_q, n_p2;
	logic [14:0] h0_q, h1_q, h2_q, n_h0, n_h1, n_h2;
	logic [3:0] pc_q, n_pc;
	logic [7:0] hold_q, n_hold;
	logic stop_q, n_stop;
	logic [7:0] col_q, n_col, a_col;
	logic [8:0] line_q, n_line, a_line;
	logic [16:0] rem_q, n_rem, a_rem;
	logic [8:0] wide_q, n_wide;
	logic [8:0] col_inc;
	logic [5:0] run_dec;
	logic [14:0] color, pal_sel;
	logic [1:0] idx;
	logic [23:0] px [4];
	logic gen, done;
	res_t res, status_res;
	res_t pend_q;
	logic pend_valid_q;

	assign color = {hold_q[6:0], byte_q};
	assign status_res = '{col: col_q, line: line_q[7:0], row: 2'd0, all: 1'b0,
		mask: 4'd0, px0: 24'd0, px1: 24'd0, px2: 24'd0, px3: 24'd0, err: ERR_NONE};

	// Position after one block.
	always_comb begin
		col_inc = {1'b0, col_q} + 9'd1;
		if (col_inc >= wide_q) begin
			a_col = 8'd0;
			a_line = line_q + 9'd1;
		end else begin
			a_col = col_inc[7:0];
			a_line = line_q;
		end
		a_rem = (rem_q != 17'd0) ? rem_q - 17'd1 : rem_q;
		run_dec = (run_q != 6'd0) ? run_q - 6'd1 : run_q;
	end

	// Palette pixels for an index byte; bits 7:6 pick the leftmost pixel.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			idx = byte_q[7 - 2*k -: 2];
			unique case (idx)
				2'd0: pal_sel = second_q;
				2'd1: pal_sel = p1_q;
				2'd2: pal_sel = p2_q;
				default: pal_sel = first_q;
			endcase
			px[k] = expand(pal_sel);
		end
	end

	always_comb begin
		n_phase = phase_q; n_hc = hc_q; n_run = run_q;
		n_first = first_q; n_second = second_q; n_p1 = p1_q; n_p2 = p2_q;
		n_h0 = h0_q; n_h1 = h1_q; n_h2 = h2_q; n_pc = pc_q; n_hold = hold_q;
		n_stop = stop_q; n_col = col_q; n_line = line_q; n_rem = rem_q; n_wide = wide_q;
		gen = 1'b0;
		done = 1'b1;
		res = status_res;
		if (!stop_q) begin
			unique case (phase_q)
				PH_HDR: begin
					if (hc_q == 2'd0) begin
						n_wide = clampdim(width_cfg_q, 9'(MAX_BLOCKS_ACROSS));
						n_rem = 17'(18'(n_wide) *
							18'(clampdim(height_cfg_q, 9'(MAX_BLOCKS_DOWN))));
						n_col = 8'd0;
						n_line = 9'd0;
					end
					n_hc = hc_q + 2'd1;
					if (hc_q == 2'd3) n_phase = PH_OPC;
				end
				PH_OPC: begin
					n_run = {1'b0, byte_q[4:0]} + 6'd1;
					priority case (byte_q[7:5])
						3'b000, 3'b001, 3'b010, 3'b011: begin
							n_hold = byte_q;
							n_phase = PH_A_LO;
						end
						3'b100: begin
							n_phase = PH_SKIP_RUN;
							done = 1'b0;
						end
						3'b101: n_phase = PH_FILL_HI;
						3'b110: n_phase = PH_PA_HI;
						default: begin
							n_stop = 1'b1;
							gen = 1'b1;
							res.err = ERR_OPCODE;
						end
					endcase
				end
				PH_SKIP_RUN: begin
					if (run_q == 6'd0) begin
						n_phase = PH_OPC;
					end else if (rem_q == 17'd0) begin
						n_phase = PH_OPC;
						n_stop = 1'b1;
						gen = 1'b1;
						res.err = ERR_OVERRUN;
					end else begin
						n_col = a_col; n_line = a_line; n_rem = a_rem;
						n_run = run_dec;
						done = 1'b0;
					end
				end
				PH_A_LO: begin
					n_first = color;
					n_phase = PH_PEEK;
				end
				PH_PEEK: begin
					n_hold = byte_q;
					if (byte_q[7]) begin
						n_run = 6'd1;
						n_phase = PH_PB_LO;
					end else if (rem_q == 17'd0) begin
						n_stop = 1'b1;
						gen = 1'b1;
						res.err = ERR_OVERRUN;
					end else begin
						n_h2 = first_q;
						n_pc = 4'd1;
						n_phase = PH_C16_LO;
					end
				end
				PH_C16_HI, PH_FILL_HI, PH_PA_HI, PH_PB_HI: begin
					n_hold = byte_q;
					n_phase = phase_t'(phase_q + 4'd1);
				end
				PH_C16_LO: begin
					// Colors of the row shift through three holding registers.
					n_h0 = h1_q; n_h1 = h2_q; n_h2 = color;
					if (pc_q[1:0] == 2'd3) begin
						gen = 1'b1;
						res.row = pc_q[3:2];
						res.mask = 4'hf;
						res.px0 = expand(h0_q);
						res.px1 = expand(h1_q);
						res.px2 = expand(h2_q);
						res.px3 = expand(color);
					end
					n_pc = pc_q + 4'd1;
					if (pc_q == 4'd15) begin
						n_col = a_col; n_line = a_line; n_rem = a_rem;
						n_phase = PH_OPC;
					end else begin
						n_phase = PH_C16_HI;
					end
				end
				PH_FILL_LO: begin
					n_first = color;
					n_phase = PH_FILL_RUN;
					done = 1'b0;
				end
				PH_FILL_RUN: begin
					if (run_q == 6'd0) begin
						n_phase = PH_OPC;
					end else if (rem_q == 17'd0) begin
						n_phase = PH_OPC;
						n_stop = 1'b1;
						gen = 1'b1;
						res.err = ERR_OVERRUN;
					end else begin
						gen = 1'b1;
						res.all = 1'b1;
						res.mask = 4'hf;
						res.px0 = expand(first_q);
						res.px1 = expand(first_q);
						res.px2 = expand(first_q);
						res.px3 = expand(first_q);
						n_col = a_col; n_line = a_line; n_rem = a_rem;
						n_run = run_dec;
						done = 1'b0;
					end
				end
				PH_PA_LO: begin
					n_first = color;
					n_phase = PH_PB_HI;
				end
				PH_PB_LO: begin
					n_second = color;
					n_p1 = mix_color(first_q, color, 5'd11, 5'd21);
					n_p2 = mix_color(first_q, color, 5'd21, 5'd11);
					if (rem_q == 17'd0) begin
						n_stop = 1'b1;
						gen = 1'b1;
						res.err = ERR_OVERRUN;
					end else begin
						n_pc = 4'd0;
						n_phase = PH_IDX;
					end
				end
				PH_IDX: begin
					gen = 1'b1;
					res.row = pc_q[1:0];
					res.mask = 4'hf;
					res.px0 = px[0];
					res.px1 = px[1];
					res.px2 = px[2];
					res.px3 = px[3];
					n_pc = pc_q + 4'd1;
					if (pc_q[1:0] == 2'd3) begin
						n_col = a_col; n_line = a_line; n_rem = a_rem;
						n_pc = 4'd0;
						n_run = run_dec;
						if (run_dec == 6'd0) begin
							n_phase = PH_OPC;
						end else if (a_rem == 17'd0) begin
							// The status result follows in the next step.
							n_phase = PH_ERR_STOP;
							done = 1'b0;
						end
					end
				end
				PH_ERR_STOP: begin
					n_phase = PH_OPC;
					n_stop = 1'b1;
					gen = 1'b1;
					res.err = ERR_OVERRUN;
				end
				default: n_phase = PH_OPC;
			endcase
		end
	end

	assign st.gen = gen;
	assign st.byte_done = done;
	assign st.out_busy = out_valid & ~out_ready;
	assign st.pend_valid = pend_valid_q;
	assign st.last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q <= RESET_WIDTH;
			height_cfg_q <= RESET_HEIGHT;
			phase_q <= PH_HDR;
			hc_q <= 2'd0;
			run_q <= 6'd0;
			first_q <= '0;
			second_q <= '0;
			pc_q <= 4'd0;
			hold_q <= 8'd0;
			stop_q <= 1'b0;
			col_q <= 8'd0;
			line_q <= 9'd0;
			wide_q <= RESET_WIDTH;
			rem_q <= 17'(18'(RESET_WIDTH) * 18'(RESET_HEIGHT));
			last_q <= 1'b0;
			out_valid <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_WIDTH: width_cfg_q <= cfg_data;
					default: height_cfg_q <= cfg_data;
				endcase
			end
			if (cmd.capture) begin
				last_q <= chunk_last;
			end
			if (cmd.step) begin
				phase_q <= n_phase; hc_q <= n_hc; run_q <= n_run;
				first_q <= n_first; second_q <= n_second;
				pc_q <= n_pc; hold_q <= n_hold; stop_q <= n_stop;
				col_q <= n_col; line_q <= n_line; rem_q <= n_rem; wide_q <= n_wide;
			end else if (cmd.close) begin
				phase_q <= PH_HDR;
				hc_q <= 2'd0;
				stop_q <= 1'b0;
				pc_q <= 4'd0;
				run_q <= 6'd0;
			end
			if (cmd.push_new || cmd.push_pend || cmd.close) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.stash) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.close) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= data_byte;
		end
		if (cmd.step) begin
			p1_q <= n_p1; p2_q <= n_p2;
			h0_q <= n_h0; h1_q <= n_h1; h2_q <= n_h2;
		end
		if (cmd.stash) begin
			pend_q <= res;
		end
		if (cmd.push_new) begin
			out_res <= res;
			out_done <= 1'b0;
		end else if (cmd.push_pend) begin
			out_res <= pend_q;
			out_done <= 1'b0;
		end else if (cmd.close) begin
			out_res <= pend_valid_q ? pend_q : status_res;
			out_done <= 1'b1;
		end
	end

endmodule

/* src/rpza_block_decoder_unit.sv */
// Block decoder for the 4x4-block RGB555 video scheme. Compressed chunk bytes
// come in one per transfer, the four header bytes first; chunk_last marks the
// final byte. Each result is a block-row write or, with all_rows set, a whole-block
// fill write, each with block position, row, pixel mask and four 8-bit R,G,B
// pixels, or a status result (mask zero) that carries an error code or closes
// a chunk. The frame size registers are read when a chunk's first header byte
// arrives, so a write applies to the next chunk. An unknown opcode or a block
// past the frame's end ends the chunk with an error and the rest of its bytes
// are dropped. Each byte is captured, then handled by parser steps. A skip
// or fill run is handled one block per cycle while the output does not
// stall, and needs one more step to see the run finish. An index byte that
// ends a block at the frame's end takes one more step for its status result.
// The final byte of a chunk is followed by a close step once the output
// register is free. Output back-pressure stalls the parser only when a
// result cannot be placed.
module rpza_block_decoder_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_write_en,
	input logic cfg_index,
	input logic [8:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic chunk_last,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] block_col,
	output logic [7:0] block_line,
	output logic [1:0] pixel_row,
	output logic all_rows,
	output logic [3:0] pixel_mask,
	output logic [23:0] pixel_zero,
	output logic [23:0] pixel_one,
	output logic [23:0] pixel_two,
	output logic [23:0] pixel_three,
	output logic chunk_done,
	output logic [1:0] error_code
);
	import rpzab_pkg::*;

	cmd_t cmd;
	stat_t st;
	res_t out_res;

	// The controller sequences capture, parser steps and chunk closing.
	rpzab_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st(st),
		.cmd(cmd)
	);

	// The datapath holds the parser state, color logic and output register.
	rpzab_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.data_byte(data_byte),
		.chunk_last(chunk_last),
		.out_ready(out_ready),
		.cmd(cmd),
		.st(st),
		.out_valid(out_valid),
		.out_res(out_res),
		.out_done(chunk_done)
	);

	assign block_col = out_res.col;
	assign block_line = out_res.line;
	assign pixel_row = out_res.row;
	assign all_rows = out_res.all;
	assign pixel_mask = out_res.mask;
	assign pixel_zero = out_res.px0;
	assign pixel_one = out_res.px1;
	assign pixel_two = out_res.px2;
	assign pixel_three = out_res.px3;
	assign error_code = out_res.err;

endmodule

/* src/rpzab_checker.sv */
module rpzab_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] pixel_row,
	input logic all_rows,
	input logic [3:0] pixel_mask,
	input logic [23:0] pixel_zero,
	input logic [1:0] error_code
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_zero))
		else $error("stalled result changed");

	// Status results carry no pixels.
	a_status_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_mask == 4'd0 |-> !all_rows && pixel_zero == 24'd0)
		else $error("status result carries pixels");

	// Fill writes cover the whole block and never carry an error.
	a_fill_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_rows |-> pixel_mask == 4'hf && pixel_row == 2'd0
			&& error_code == 2'd0)
		else $error("malformed fill write");

	// An error only comes on a status result.
	a_err_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != 2'd0 |-> pixel_mask == 4'd0)
		else $error("error on a pixel write");

endmodule

bind rpza_block_decoder_unit rpzab_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.pixel_row(pixel_row),
	.all_rows(all_rows),
	.pixel_mask(pixel_mask),
	.pixel_zero(pixel_zero),
	.error_code(error_code)
);
